// ===== sv/bcu_pkg.sv =====
// shared types and constants of the branch and control unit
`default_nettype none

package bcu_pkg;

	// instruction classes
	typedef enum logic [3:0] {
		CMD_JP     = 4'd0,
		CMD_JP_HL  = 4'd1,
		CMD_JR     = 4'd2,
		CMD_JR_CC  = 4'd3,
		CMD_CALL   = 4'd4,
		CMD_CALL_CC = 4'd5,
		CMD_RET    = 4'd6,
		CMD_RET_CC = 4'd7,
		CMD_RETI   = 4'd8,
		CMD_RST    = 4'd9,
		CMD_DI     = 4'd10,
		CMD_EI     = 4'd11,
		CMD_HALT   = 4'd12,
		CMD_STOP   = 4'd13
	} bcu_cmd_t;

	// branch conditions
	typedef enum logic [2:0] {
		COND_NONE = 3'd0,
		COND_Z    = 3'd1,
		COND_NZ   = 3'd2,
		COND_C    = 3'd3,
		COND_NC   = 3'd4
	} bcu_cond_t;

	// output beat sequencer
	typedef enum logic [1:0] {
		BEAT_HI,
		BEAT_LO,
		BEAT_STATUS
	} bcu_beat_t;

	localparam logic [7:0] RST_MASK  = 8'h38;
	localparam int         BYTE_BITS = 8;

	typedef struct packed {
		logic [3:0]        cmd;
		logic [2:0]        cond;
		logic [7:0]        opcode;
		logic [15:0]       imm_word;
		logic signed [7:0] imm_offset;
		logic [15:0]       hl_value;
		logic              zero_flag;
		logic              carry_flag;
		logic [7:0]        stack_low;
		logic [7:0]        stack_high;
	} bcu_in_t;

	typedef struct packed {
		logic        is_write;
		logic [15:0] write_addr;
		logic [7:0]  write_data;
		logic [15:0] new_pc;
		logic [15:0] new_sp;
		logic        ime_out;
		logic        ime_pending_out;
		logic        halted_out;
		logic        stopped_out;
		logic        last;
	} bcu_out_t;

	// one classified instruction waiting for the back end
	typedef struct packed {
		logic        has_push;
		logic [15:0] push_addr_hi;
		logic [15:0] push_pc;
		logic [15:0] pc;
		logic [15:0] sp;
		logic        ime;
		logic        ime_pending;
		logic        halted;
		logic        stopped;
	} bcu_job_t;

endpackage

`default_nettype wire

// ===== sv/bcu_front.sv =====
// front end: accepts instructions, updates pc, sp and flags, queues a job
`default_nettype none

module bcu_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire bcu_pkg::bcu_in_t in_data,
	input  wire logic             q_full,
	output logic                  job_valid,
	output bcu_pkg::bcu_job_t     job
);

	logic [15:0] pc_q;
	logic [15:0] sp_q;
	logic        ime_q;
	logic        ime_pending_q;
	logic        halted_q;
	logic        stopped_q;

	logic [15:0] pc_d;
	logic [15:0] sp_d;
	logic        ime_d;
	logic        push;
	logic        take;
	logic [15:0] disp;
	logic [15:0] pc_rel;
	logic [15:0] pop_pc;
	logic [15:0] sp_pop;
	logic [15:0] sp_push;
	logic        accept;

	function automatic logic cond_true(input logic [2:0] c, input logic z, input logic cy);
		logic r;
		case (c)
			bcu_pkg::COND_NONE: r = 1'b1;
			bcu_pkg::COND_Z:    r = z;
			bcu_pkg::COND_NZ:   r = ~z;
			bcu_pkg::COND_C:    r = cy;
			bcu_pkg::COND_NC:   r = ~cy;
			default:            r = 1'b0;
		endcase
		return r;
	endfunction

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;

	assign take    = cond_true(in_data.cond, in_data.zero_flag, in_data.carry_flag);
	assign disp    = {{8{in_data.imm_offset[7]}}, in_data.imm_offset};
	assign pc_rel  = pc_q + disp;
	assign pop_pc  = {in_data.stack_high, in_data.stack_low};
	assign sp_pop  = sp_q + 16'd2;
	assign sp_push = sp_q - 16'd2;

	always_comb begin
		pc_d  = pc_q;
		sp_d  = sp_q;
		ime_d = ime_q;
		push  = 1'b0;
		unique case (in_data.cmd)
			bcu_pkg::CMD_JP:    pc_d = in_data.imm_word;
			bcu_pkg::CMD_JP_HL: pc_d = in_data.hl_value;
			bcu_pkg::CMD_JR:    pc_d = pc_rel;
			bcu_pkg::CMD_JR_CC: begin
				if (take) begin
					pc_d = pc_rel;
				end
			end
			bcu_pkg::CMD_CALL: begin
				push = 1'b1;
				sp_d = sp_push;
				pc_d = in_data.imm_word;
			end
			bcu_pkg::CMD_CALL_CC: begin
				if (take) begin
					push = 1'b1;
					sp_d = sp_push;
					pc_d = in_data.imm_word;
				end
			end
			bcu_pkg::CMD_RET: begin
				pc_d = pop_pc;
				sp_d = sp_pop;
			end
			bcu_pkg::CMD_RET_CC: begin
				if (take) begin
					pc_d = pop_pc;
					sp_d = sp_pop;
				end
			end
			bcu_pkg::CMD_RETI: begin
				pc_d  = pop_pc;
				sp_d  = sp_pop;
				ime_d = 1'b1;
			end
			bcu_pkg::CMD_RST: begin
				push = 1'b1;
				sp_d = sp_push;
				pc_d = {8'h00, in_data.opcode & bcu_pkg::RST_MASK};
			end
			bcu_pkg::CMD_DI: ime_d = 1'b0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q          <= '0;
			sp_q          <= '0;
			ime_q         <= 1'b0;
			ime_pending_q <= 1'b0;
			halted_q      <= 1'b0;
			stopped_q     <= 1'b0;
		end else if (accept) begin
			pc_q  <= pc_d;
			sp_q  <= sp_d;
			ime_q <= ime_d;
			if (in_data.cmd == bcu_pkg::CMD_EI) begin
				ime_pending_q <= 1'b1;
			end
			if (in_data.cmd == bcu_pkg::CMD_HALT) begin
				halted_q <= 1'b1;
			end
			if (in_data.cmd == bcu_pkg::CMD_STOP) begin
				stopped_q <= 1'b1;
			end
		end
	end

	assign job_valid         = accept;
	assign job.has_push      = push;
	assign job.push_addr_hi  = sp_q - 16'd1;
	assign job.push_pc       = pc_q;
	assign job.pc            = pc_d;
	assign job.sp            = sp_d;
	assign job.ime           = ime_d;
	assign job.ime_pending   = ime_pending_q | (in_data.cmd == bcu_pkg::CMD_EI);
	assign job.halted        = halted_q | (in_data.cmd == bcu_pkg::CMD_HALT);
	assign job.stopped       = stopped_q | (in_data.cmd == bcu_pkg::CMD_STOP);

`ifndef SYNTH
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.cmd == bcu_pkg::CMD_HALT |=> halted_q)
		else $error("halt flag not set after halt");
`endif

endmodule

`default_nettype wire

// ===== sv/bcu_queue.sv =====
// small job queue between front and back end
`default_nettype none

module bcu_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire bcu_pkg::bcu_job_t push_data,
	input  wire logic              pop,
	output bcu_pkg::bcu_job_t      head,
	output logic                   empty,
	output logic                   full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bcu_pkg::bcu_job_t entries_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q < CW'(DEPTH))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== sv/bcu_back.sv =====
// back end: turns queued jobs into stack write beats and a status beat
`default_nettype none

module bcu_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcu_pkg::bcu_job_t head,
	input  wire logic              q_empty,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bcu_pkg::bcu_out_t      out_data
);

	bcu_pkg::bcu_beat_t state_q;
	bcu_pkg::bcu_beat_t state_d;
	logic               out_valid_q;
	bcu_pkg::bcu_out_t  out_q;
	bcu_pkg::bcu_out_t  beat;
	logic               load;
	logic               emit;
	logic               emit_status;

	assign load = ~out_valid_q | out_ready;
	assign emit = load & ~q_empty;

	// next state
	always_comb begin
		state_d = state_q;
		if (emit) begin
			unique case (state_q)
				bcu_pkg::BEAT_HI:     state_d = head.has_push ? bcu_pkg::BEAT_LO
				                                              : bcu_pkg::BEAT_HI;
				bcu_pkg::BEAT_LO:     state_d = bcu_pkg::BEAT_STATUS;
				bcu_pkg::BEAT_STATUS: state_d = bcu_pkg::BEAT_HI;
				default:              state_d = bcu_pkg::BEAT_HI;
			endcase
		end
	end

	// beat contents
	always_comb begin
		beat        = '0;
		emit_status = 1'b0;
		unique case (state_q)
			bcu_pkg::BEAT_HI: begin
				if (head.has_push) begin
					beat.is_write   = 1'b1;
					beat.write_addr = head.push_addr_hi;
					beat.write_data = head.push_pc[15:bcu_pkg::BYTE_BITS];
				end else begin
					emit_status = 1'b1;
				end
			end
			bcu_pkg::BEAT_LO: begin
				beat.is_write   = 1'b1;
				beat.write_addr = head.sp;
				beat.write_data = head.push_pc[bcu_pkg::BYTE_BITS-1:0];
			end
			default: emit_status = 1'b1;
		endcase
		if (emit_status) begin
			beat.new_pc          = head.pc;
			beat.new_sp          = head.sp;
			beat.ime_out         = head.ime;
			beat.ime_pending_out = head.ime_pending;
			beat.halted_out      = head.halted;
			beat.stopped_out     = head.stopped;
			beat.last            = 1'b1;
		end
	end

	assign pop = emit & emit_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bcu_pkg::BEAT_HI;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= ~q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	a_lo_follows_hi: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcu_pkg::BEAT_LO |-> out_valid_q && out_q.is_write)
		else $error("low byte write without pending high byte write");
	a_write_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.is_write |-> !out_q.last)
		else $error("write beat marked last");
	a_hi_before_lo: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bcu_pkg::BEAT_LO && $past(state_q) == bcu_pkg::BEAT_HI |-> $past(emit))
		else $error("sequencer advanced without a beat");
`endif

endmodule

`default_nettype wire

// ===== sv/cpu_branch_control_unit.sv =====
// top level of the branch and control unit
`default_nettype none

// Executes jumps, calls, returns, RST, DI, EI, HALT and STOP of an 8-bit CPU
// and keeps pc, sp, ime, the pending enable and the halt and stop flags.
// Every instruction yields a status beat (last = 1); a taken call or RST is
// preceded by two stack write beats, high byte at sp-1 first, then low byte
// at sp-2. Pops take the low byte from stack_low and the high byte from
// stack_high. The front end accepts one instruction per cycle while the
// queue is not full and updates the architectural state at once, so the
// next instruction may follow in the next cycle; classified jobs wait in a
// queue of QUEUE_DEPTH entries. The back end sends one beat per cycle while
// out_ready allows through a registered output, so an instruction yields one
// output beat, or three for a taken call or RST; the output port's one beat
// per cycle sets the sustained rate. A job passes the queue, then the output
// register. Back pressure on the output fills the queue, then drops in_ready.

module cpu_branch_control_unit #(
	parameter int QUEUE_DEPTH = 4  // job queue entries, at least two
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bcu_pkg::bcu_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bcu_pkg::bcu_out_t      out_data
);

	// front to queue
	logic              job_valid;
	bcu_pkg::bcu_job_t job;

	// queue to back end
	bcu_pkg::bcu_job_t head;
	logic              q_empty;
	logic              q_full;
	logic              q_pop;

	// decode and state update of each accepted instruction
	bcu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.job_valid (job_valid),
		.job       (job)
	);

	// decouples instruction intake from result delivery
	bcu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_valid),
		.push_data (job),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// beat sequencer with output register
	bcu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
